// File: hw/rtl/quoted_field_splitter_core_defines.svh
// assertion macros shared by the quoted field splitter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef QUOTED_FIELD_SPLITTER_CORE_DEFINES_SVH
`define QUOTED_FIELD_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define QFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qfs check failed");

// next-cycle implication, disabled while reset is asserted
`define QFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qfs check failed");

`endif

// File: hw/rtl/qfs_pkg.sv
// package for the quoted field splitter: constants, register indexes, queue entry type
// no dependencies; used by the core, front, queue and back rtl files of the block
package qfs_pkg;

  // fixed byte that is always literal after an escape
  localparam logic [7:0] DQUOTE_BYTE = 8'h22;

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd2;
  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] ESCAPE_RESET    = 8'd92;

  // input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified item: optional leading escape result, then the final result
  typedef struct packed {
    logic       pair;
    logic [7:0] esc_byte;
    logic       has_char;
    logic [7:0] char_out;
    logic       field_end;
    logic       string_end;
  } qfs_entry_t;

endpackage

// File: hw/rtl/qfs_in_if.sv
// input channel interface of the quoted field splitter
// depends on nothing; carries valid, ready and one input item
interface qfs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

// File: hw/rtl/qfs_out_if.sv
// result channel interface of the quoted field splitter
// depends on nothing; carries valid, ready and one result item
interface qfs_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] char_out;
  logic       field_end;
  logic       string_end;
  logic       last;

  modport source (output valid, output has_char, output char_out, output field_end,
                  output string_end, output last, input ready);
  modport sink   (input valid, input has_char, input char_out, input field_end,
                  input string_end, input last, output ready);
endinterface

// File: hw/rtl/quoted_field_splitter_core.sv
// Quoted field splitter: takes one byte or end-of-string item per cycle and turns it into
// zero, one or two field results. Input is accepted every cycle while the 4-entry queue
// between the classifying front end and the output back end has room; a result passes
// through the queue and then the output register before it appears on out_if. The output
// register delivers one result per cycle while out_if is ready; an escaped ordinary byte
// inside quotes yields two results, and the queue absorbs that until it fills. Configuration
// writes on cfg_* take effect on the next item and should only be made while idle.
// top level; depends on qfs_pkg, qfs_in_if, qfs_out_if, qfs_front, qfs_queue, qfs_back
module quoted_field_splitter_core
  import qfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qfs_in_if.sink               in_if,
  qfs_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  qfs_entry_t push_entry, head_entry;
  logic       push, pop, full, empty;

  // classification
  qfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // decoupling queue
  qfs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // result delivery
  qfs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

// File: hw/rtl/qfs_front.sv
// front end: config registers, parse state, classification of each input item
// depends on qfs_pkg and qfs_in_if; pushes classified entries into qfs_queue
module qfs_front
  import qfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qfs_in_if.sink               in_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  input  logic                 full_i,
  output logic                 push_o,
  output qfs_entry_t           entry_o
);

  logic [7:0] delimiter_r, quote_r, escape_r;
  logic       in_quotes_r, esc_pend_r, field_has_r;
  logic       in_quotes_nxt, esc_pend_nxt, field_has_nxt;
  logic       push_item;
  logic       accept;
  logic [7:0] c;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign c           = in_if.char_in;
  assign push_o      = accept && push_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= DELIMITER_RESET;
      quote_r     <= QUOTE_RESET;
      escape_r    <= ESCAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DELIMITER: delimiter_r <= cfg_wdata;
        CFG_QUOTE:     quote_r     <= cfg_wdata;
        CFG_ESCAPE:    escape_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classification, rules in priority order
  always_comb begin
    in_quotes_nxt       = in_quotes_r;
    esc_pend_nxt        = esc_pend_r;
    field_has_nxt       = field_has_r;
    push_item           = 1'b1;
    entry_o.pair        = 1'b0;
    entry_o.esc_byte    = escape_r;
    entry_o.has_char    = 1'b1;
    entry_o.char_out    = c;
    entry_o.field_end   = 1'b0;
    entry_o.string_end  = 1'b0;
    if (in_if.opcode == OP_EOS) begin
      // flush pending escape, close non-empty field, clear state
      entry_o.has_char   = esc_pend_r;
      entry_o.char_out   = esc_pend_r ? escape_r : 8'd0;
      entry_o.field_end  = field_has_r || esc_pend_r;
      entry_o.string_end = 1'b1;
      in_quotes_nxt      = 1'b0;
      esc_pend_nxt       = 1'b0;
      field_has_nxt      = 1'b0;
    end else if (esc_pend_r) begin
      esc_pend_nxt  = 1'b0;
      field_has_nxt = 1'b1;
      if (c != DQUOTE_BYTE && c != escape_r && in_quotes_r) begin
        entry_o.pair = 1'b1;
      end
    end else if (c == escape_r) begin
      esc_pend_nxt = 1'b1;
      push_item    = 1'b0;
    end else if (c == delimiter_r) begin
      if (in_quotes_r) begin
        field_has_nxt = 1'b1;
      end else begin
        field_has_nxt     = 1'b0;
        entry_o.has_char  = 1'b0;
        entry_o.char_out  = 8'd0;
        entry_o.field_end = 1'b1;
      end
    end else if (c == quote_r) begin
      in_quotes_nxt = !in_quotes_r;
      push_item     = 1'b0;
    end else begin
      field_has_nxt = 1'b1;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      esc_pend_r  <= 1'b0;
      field_has_r <= 1'b0;
    end else if (accept) begin
      in_quotes_r <= in_quotes_nxt;
      esc_pend_r  <= esc_pend_nxt;
      field_has_r <= field_has_nxt;
    end
  end

endmodule

// File: hw/rtl/qfs_queue.sv
// short queue of classified entries between front and back
// depends on qfs_pkg and the assertion macro header
`include "quoted_field_splitter_core_defines.svh"
module qfs_queue
  import qfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  qfs_entry_t entry_i,
  input  logic       pop_i,
  output qfs_entry_t entry_o,
  output logic       full_o,
  output logic       empty_o
);

  qfs_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full_o  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign entry_o = slots[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      slots[wr_ptr_r] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `QFS_ASSERT_NOW(a_no_overflow, clk, rst_n, push_i, !full_o)
  `QFS_ASSERT_NOW(a_no_underflow, clk, rst_n, pop_i, !empty_o)
  `QFS_ASSERT_NEXT(a_count_holds, clk, rst_n, !push_i && !pop_i, $stable(count_r))

endmodule

// File: hw/rtl/qfs_back.sv
// back end: expands queue entries into one or two results behind an output register
// depends on qfs_pkg, qfs_out_if and the assertion macro header
`include "quoted_field_splitter_core_defines.svh"
module qfs_back
  import qfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qfs_entry_t entry_i,
  input  logic       empty_i,
  output logic       pop_o,
  qfs_out_if.source  out_if
);

  logic       out_valid_r;
  logic       pend_r;
  logic       out_has_char_r, out_field_end_r, out_string_end_r, out_last_r;
  logic [7:0] out_char_r;
  logic       pend_has_char_r, pend_field_end_r, pend_string_end_r;
  logic [7:0] pend_char_r;
  logic       load;

  assign load  = !out_valid_r || out_if.ready;
  assign pop_o = load && !pend_r && !empty_i;

  assign out_if.valid      = out_valid_r;
  assign out_if.has_char   = out_has_char_r;
  assign out_if.char_out   = out_char_r;
  assign out_if.field_end  = out_field_end_r;
  assign out_if.string_end = out_string_end_r;
  assign out_if.last       = out_last_r;

  // output valid and second-result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= !empty_i;
        pend_r      <= !empty_i && entry_i.pair;
      end
    end
  end

  // output and pending payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_has_char_r   <= pend_has_char_r;
        out_char_r       <= pend_char_r;
        out_field_end_r  <= pend_field_end_r;
        out_string_end_r <= pend_string_end_r;
        out_last_r       <= 1'b1;
      end else if (entry_i.pair) begin
        // escape byte goes first, the byte itself waits
        out_has_char_r    <= 1'b1;
        out_char_r        <= entry_i.esc_byte;
        out_field_end_r   <= 1'b0;
        out_string_end_r  <= 1'b0;
        out_last_r        <= 1'b0;
        pend_has_char_r   <= entry_i.has_char;
        pend_char_r       <= entry_i.char_out;
        pend_field_end_r  <= entry_i.field_end;
        pend_string_end_r <= entry_i.string_end;
      end else begin
        out_has_char_r   <= entry_i.has_char;
        out_char_r       <= entry_i.char_out;
        out_field_end_r  <= entry_i.field_end;
        out_string_end_r <= entry_i.string_end;
        out_last_r       <= 1'b1;
      end
    end
  end

  `QFS_ASSERT_NOW(a_pend_needs_out, clk, rst_n, pend_r, out_valid_r && !out_last_r)
  `QFS_ASSERT_NEXT(a_second_follows, clk, rst_n, pend_r && out_if.ready,
                   out_valid_r && out_last_r)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for quoted_field_splitter_core: directed table, then random records
// uses qfs_pkg, qfs_in_if and qfs_out_if; results are checked against a local field model or hand-typed rows
module testbench;
  import qfs_pkg::*;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic       field_end;
    logic       string_end;
    logic       last;
  } field_result_t;

  // one row of the directed table; typed rows carry their results written out by hand
  typedef struct {
    logic          op;
    logic [7:0]    ch;
    bit            typed;
    int            n;
    field_result_t r0;
    field_result_t r1;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [7:0]           cfg_wdata;

  qfs_in_if  in_if ();
  qfs_out_if out_if ();

  quoted_field_splitter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // field model: register copies and splitter state
  logic [7:0] delim_cfg   = DELIMITER_RESET;
  logic [7:0] quote_cfg   = QUOTE_RESET;
  logic [7:0] esc_cfg     = ESCAPE_RESET;
  logic       quoted_mode = 1'b0;
  logic       esc_armed   = 1'b0;
  logic       field_open  = 1'b0;

  field_result_t field_results_due[$];
  dir_step_t     dir_rows[$];

  // hand-typed expectation for the transfer currently offered
  bit            hand_typed = 1'b0;
  int            hand_n;
  field_result_t hand_r0;
  field_result_t hand_r1;

  int send_idle_pct = 21;
  int recv_idle_pct = 82;
  int items_sent    = 0;
  int mismatches    = 0;

  function automatic field_result_t res(input logic hc, input logic [7:0] ch, input logic fe,
                                        input logic se, input logic lst);
    return {hc, ch, fe, se, lst};
  endfunction

  function automatic dir_step_t step(input logic op, input logic [7:0] ch, input bit typed,
                                     input int n, input field_result_t r0,
                                     input field_result_t r1);
    dir_step_t s;
    s.op = op;
    s.ch = ch;
    s.typed = typed;
    s.n = n;
    s.r0 = r0;
    s.r1 = r1;
    return s;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_step_t s);
    dir_rows = {dir_rows, s};
  endfunction

  // splits one input item; returns how many field results it yields
  function automatic int split_byte(input logic op, input logic [7:0] ch,
                                    output field_result_t r0, output field_result_t r1);
    r0 = '0;
    r1 = '0;
    // end of string: flush a pending escape, close a non-empty field, clear state
    if (op == OP_EOS) begin
      r0 = res(esc_armed, esc_armed ? esc_cfg : 8'h00, field_open | esc_armed, 1'b1, 1'b1);
      quoted_mode = 1'b0;
      esc_armed = 1'b0;
      field_open = 1'b0;
      return 1;
    end
    // byte after an escape
    if (esc_armed) begin
      esc_armed = 1'b0;
      field_open = 1'b1;
      if (ch != DQUOTE_BYTE && ch != esc_cfg && quoted_mode) begin
        r0 = res(1'b1, esc_cfg, 1'b0, 1'b0, 1'b0);
        r1 = res(1'b1, ch, 1'b0, 1'b0, 1'b1);
        return 2;
      end
      r0 = res(1'b1, ch, 1'b0, 1'b0, 1'b1);
      return 1;
    end
    if (ch == esc_cfg) begin
      esc_armed = 1'b1;
      return 0;
    end
    // delimiter outside quotes ends the field; inside quotes it is plain data
    if (ch == delim_cfg) begin
      if (!quoted_mode) begin
        field_open = 1'b0;
        r0 = res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
        return 1;
      end
    end else if (ch == quote_cfg) begin
      quoted_mode = !quoted_mode;
      return 0;
    end
    field_open = 1'b1;
    r0 = res(1'b1, ch, 1'b0, 1'b0, 1'b1);
    return 1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input transfers feed the model, result transfers are checked in order
  always @(posedge clk) begin
    field_result_t p0, p1, want;
    int n;
    if (rst_n && in_if.valid && in_if.ready) begin
      n = split_byte(in_if.opcode, in_if.char_in, p0, p1);
      if (hand_typed) begin
        n = hand_n;
        p0 = hand_r0;
        p1 = hand_r1;
      end
      if (n > 0) field_results_due = {field_results_due, p0};
      if (n > 1) field_results_due = {field_results_due, p1};
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (field_results_due.size() == 0) begin
        $error("result transfer with none due: char_out 0x%0h", out_if.char_out);
        mismatches++;
      end else begin
        want = field_results_due.pop_front();
        check_field("has_char", 8'(want.has_char), 8'(out_if.has_char));
        check_field("char_out", want.char_out, out_if.char_out);
        check_field("field_end", 8'(want.field_end), 8'(out_if.field_end));
        check_field("string_end", 8'(want.string_end), 8'(out_if.string_end));
        check_field("last", 8'(want.last), 8'(out_if.last));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    // now and then hold off until every due result has come out
    if ($urandom_range(99) < 2) begin
      in_if.valid <= 1'b0;
      do @(negedge clk); while (field_results_due.size() != 0);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.opcode <= ($urandom_range(1) == 1);
      in_if.char_in <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.char_in <= ch;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // stop sending, wait for all due results, then let the pipeline settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (field_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] delim, input logic [7:0] quote,
                            input logic [7:0] esc);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_DELIMITER;
    cfg_wdata <= delim;
    @(negedge clk);
    cfg_addr <= CFG_QUOTE;
    cfg_wdata <= quote;
    @(negedge clk);
    cfg_addr <= CFG_ESCAPE;
    cfg_wdata <= esc;
    @(negedge clk);
    cfg_we <= 1'b0;
    delim_cfg = delim;
    quote_cfg = quote;
    esc_cfg = esc;
  endtask

  // one csv-like record: fields, some quoted, with escapes, usually closed by end of string
  task automatic send_record();
    int   n_fields;
    int   len;
    logic quoted;
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      quoted = ($urandom_range(99) < 45);
      if (quoted) send_item(OP_CHAR, quote_cfg);
      len = $urandom_range(0, 5);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0, 1: begin
            send_item(OP_CHAR, esc_cfg);
            case ($urandom_range(4))
              0: send_item(OP_CHAR, DQUOTE_BYTE);
              1: send_item(OP_CHAR, esc_cfg);
              2: send_item(OP_CHAR, delim_cfg);
              3: send_item(OP_CHAR, quote_cfg);
              default: send_item(OP_CHAR, 8'($urandom_range(255)));
            endcase
          end
          2: send_item(OP_CHAR, delim_cfg);
          3: send_item(OP_CHAR, DQUOTE_BYTE);
          default: send_item(OP_CHAR, 8'($urandom_range(255)));
        endcase
      end
      if (quoted) send_item(OP_CHAR, quote_cfg);
      if (f != n_fields - 1) send_item(OP_CHAR, delim_cfg);
    end
    if ($urandom_range(9) != 0) send_item(OP_EOS, 8'($urandom_range(255)));
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DELIMITER;
    cfg_wdata = 8'h00;
    in_if.valid = 1'b0;
    in_if.opcode = OP_CHAR;
    in_if.char_in = 8'h00;
    out_if.ready = 1'b0;

    // directed table under reset register values
    add_row(step(OP_EOS, 8'h00, 1'b1, 1, res(1'b0, 8'h00, 1'b0, 1'b1, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h00, 1'b1, 1, res(1'b1, 8'h00, 1'b0, 1'b0, 1'b1), '0));
    add_row(step(OP_CHAR, 8'hFF, 1'b1, 1, res(1'b1, 8'hFF, 1'b0, 1'b0, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h2C, 1'b1, 1, res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h2C, 1'b1, 1, res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h22, 1'b1, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h2C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h6E, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h22, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h22, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h78, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h5C, 1'b0, 0, '0, '0));
    add_row(step(OP_EOS, 8'h00, 1'b1, 1, res(1'b1, 8'h5C, 1'b1, 1'b1, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h71, 1'b0, 0, '0, '0));
    add_row(step(OP_EOS, 8'hFF, 1'b1, 1, res(1'b0, 8'h00, 1'b1, 1'b1, 1'b1), '0));
    add_row(step(OP_EOS, 8'hFF, 1'b1, 1, res(1'b0, 8'h00, 1'b0, 1'b1, 1'b1), '0));
    add_row(step(OP_CHAR, 8'h22, 1'b0, 0, '0, '0));
    add_row(step(OP_EOS, 8'h00, 1'b0, 0, '0, '0));
    add_row(step(OP_CHAR, 8'h2C, 1'b0, 0, '0, '0));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      hand_typed = dir_rows[i].typed;
      hand_n = dir_rows[i].n;
      hand_r0 = dir_rows[i].r0;
      hand_r1 = dir_rows[i].r1;
      send_item(dir_rows[i].op, dir_rows[i].ch);
    end
    hand_typed = 1'b0;
    drain_results();

    // random records over several register settings and stall patterns
    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: set_config(DELIMITER_RESET, QUOTE_RESET, ESCAPE_RESET);
        1: set_config(8'h00, 8'hFF, DQUOTE_BYTE);
        2: set_config(8'hFF, 8'h00, 8'hFF);
        3: set_config(8'h09, 8'h27, 8'h5C);
        4: set_config(8'h3B, 8'h3B, 8'h25);
        5: set_config(8'h7C, 8'h5E, 8'h5E);
        6: set_config(8'hAA, 8'hAA, 8'hAA);
        7: set_config(8'h01, 8'h80, 8'h00);
        default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
      endcase
      target = items_sent + 64;
      while (items_sent < target) begin
        if ($urandom_range(99) < 15) begin
          // noise: raw bytes and stray end-of-string items
          repeat ($urandom_range(1, 6))
            send_item(($urandom_range(9) == 0), 8'($urandom_range(255)));
        end else begin
          send_record();
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
